// File: hw/rtl/metronome_tone_burst_generator_unit_defines.svh
// Assertion macros shared by the tone burst generator RTL.
`ifndef METRONOME_TONE_BURST_GENERATOR_UNIT_DEFINES_SVH
`define METRONOME_TONE_BURST_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define MTBG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtbg: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define MTBG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtbg: next-cycle check failed");
`else
`define MTBG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTBG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/mtbg_pkg.sv
// Types and constants shared by the tone burst generator modules.
`timescale 1ns / 1ps
`default_nettype none

package mtbg_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PERIOD    = 3'd0;
    localparam logic [2:0] REG_TONE      = 3'd1;
    localparam logic [2:0] REG_ATTACK    = 3'd2;
    localparam logic [2:0] REG_DECAY     = 3'd3;
    localparam logic [2:0] REG_STEP      = 3'd4;
    localparam logic [2:0] REG_MAX_LEVEL = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef struct packed {
        logic [19:0] period;
        logic [19:0] tone;
        logic [19:0] attack;
        logic [19:0] decay;
        logic [23:0] phase_step;
        logic [14:0] max_level;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        period:     20'd48000,
        tone:       20'd4800,
        attack:     20'd48,
        decay:      20'd480,
        phase_step: 24'd307582,
        max_level:  15'd16384
    };

    // Sine polynomial coefficients, Q15
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;

    // Envelope quotient is below 2^15, one bit per divider step
    localparam int DIV_STEPS = 15;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

`default_nettype wire

// File: hw/rtl/mtbg_front.sv
// Front end: configuration registers, request acceptance and frame count clamping.
`timescale 1ns / 1ps
`default_nettype none

module mtbg_front
    import mtbg_pkg::*;
#(
    parameter int MAX_BLOCK = 64,
    parameter int CNT_W     = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [6:0]            i_frames,
    input  logic                  i_q_full,
    output logic                  o_push,
    output logic [CNT_W-1:0]      o_push_data
);

    localparam logic [6:0] MAX_FRAMES = 7'(MAX_BLOCK);

    t_cfg       r_cfg;
    logic [6:0] frames_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PERIOD:    r_cfg.period     <= i_cfg_data[19:0];
                REG_TONE:      r_cfg.tone       <= i_cfg_data[19:0];
                REG_ATTACK:    r_cfg.attack     <= i_cfg_data[19:0];
                REG_DECAY:     r_cfg.decay      <= i_cfg_data[19:0];
                REG_STEP:      r_cfg.phase_step <= i_cfg_data[23:0];
                REG_MAX_LEVEL: r_cfg.max_level  <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // Clamp oversize requests; drop empty ones after the transfer
    assign frames_sat  = (i_frames > MAX_FRAMES) ? MAX_FRAMES : i_frames;
    assign o_in_stall  = i_q_full;
    assign o_push      = i_in_valid && !i_q_full && (i_frames != 7'd0);
    assign o_push_data = frames_sat[CNT_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/mtbg_queue.sv
// Short request queue that decouples the front end from the sample engine.
`timescale 1ns / 1ps
`default_nettype none
`include "metronome_tone_burst_generator_unit_defines.svh"

module mtbg_queue
    import mtbg_pkg::*;
#(
    parameter int WIDTH = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    `MTBG_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, o_full, !i_push)
    `MTBG_ASSERT_IMP(a_q_no_underflow, i_clk, i_rst_n, o_empty, !i_pop)
    `MTBG_ASSERT_IMP(a_q_full_ptrs, i_clk, i_rst_n, o_full, r_wr_ptr == r_rd_ptr)

endmodule

`default_nettype wire

// File: hw/rtl/mtbg_engine.sv
// Sample engine: position and phase tracking, sine polynomial, envelope divider, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "metronome_tone_burst_generator_unit_defines.svh"

module mtbg_engine
    import mtbg_pkg::*;
#(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10,
    parameter int CNT_W           = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    input  logic [CNT_W-1:0]   i_q_data,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample,
    output logic               o_last
);

    localparam int STEP_W   = 56;
    localparam int STEP_SHL = (PHASE_BITS >= 24) ? (PHASE_BITS - 24) : 0;
    localparam int STEP_SHR = (PHASE_BITS < 24) ? (24 - PHASE_BITS) : 0;

    // Sine sub-steps run alongside the divider iterations
    localparam logic [DIV_CNT_W-1:0] SIN_STEP_T1  = DIV_CNT_W'(0);
    localparam logic [DIV_CNT_W-1:0] SIN_STEP_T2  = DIV_CNT_W'(1);
    localparam logic [DIV_CNT_W-1:0] SIN_STEP_MAG = DIV_CNT_W'(2);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_PREP,
        S_MULT,
        S_DIV,
        S_ENV,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_left;
    logic [19:0]             r_pos;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [19:0]             r_num;
    logic [19:0]             r_den;
    logic [14:0]             r_z;
    logic                    r_neg;
    logic [14:0]             r_z2;
    logic [14:0]             r_t1;
    logic [15:0]             r_t2;
    logic [14:0]             r_s;
    logic [19:0]             r_rem;
    logic [14:0]             r_dlow;
    logic [14:0]             r_quo;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic [14:0]             r_mag;
    logic                    r_out_valid;
    logic signed [15:0]      r_sample;
    logic                    r_last;

    logic [19:0]                period_eff;
    logic [STEP_W-1:0]          step_wide;
    logic [PHASE_BITS-1:0]      step_scaled;
    logic [SINE_TABLE_BITS-1:0] sin_idx;
    logic [1:0]                 quad;
    logic [13:0]                z_raw;
    logic [14:0]                z_fold;
    logic                       in_tone;
    logic                       in_rise;
    logic                       in_flat;
    logic [20:0]                pos_dec;
    logic [19:0]                tone_left;
    logic [34:0]                lvl_prod;
    logic [29:0]                z_sq;
    logic [20:0]                trial;
    logic                       trial_ge;
    logic [20:0]                trial_diff;
    logic [31:0]                c_prod;
    logic [31:0]                b_prod;
    logic [31:0]                a_prod;
    logic [15:0]                t1_full;
    logic [15:0]                t2_full;
    logic [29:0]                mag_prod;
    logic [20:0]                pos_inc;
    logic                       pos_wrap;
    logic [15:0]                mag16;
    logic                       out_load;
    logic                       is_last;

    // A zero period behaves as a period of one
    assign period_eff  = (i_cfg.period == '0) ? 20'd1 : i_cfg.period;
    assign step_wide   = ({32'd0, i_cfg.phase_step} << STEP_SHL) >> STEP_SHR;
    assign step_scaled = step_wide[PHASE_BITS-1:0];

    // Fold the quadrant so z runs 0..1 in Q14
    assign sin_idx = r_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quad    = sin_idx[SINE_TABLE_BITS-1 -: 2];
    assign z_raw   = 14'(sin_idx) << (16 - SINE_TABLE_BITS);
    assign z_fold  = quad[0] ? (15'd16384 - {1'b0, z_raw}) : {1'b0, z_raw};

    // Envelope segment: rise, flat, fall in that order of precedence
    assign in_tone   = r_pos < i_cfg.tone;
    assign in_rise   = r_pos < i_cfg.attack;
    assign pos_dec   = {1'b0, r_pos} + {1'b0, i_cfg.decay};
    assign in_flat   = pos_dec < {1'b0, i_cfg.tone};
    assign tone_left = i_cfg.tone - r_pos;

    assign lvl_prod = 35'(i_cfg.max_level) * 35'(r_num);
    assign z_sq     = 30'(r_z) * 30'(r_z);

    // Restoring divider, one quotient bit a cycle
    assign trial      = {r_rem, r_dlow[14]};
    assign trial_ge   = trial >= {1'b0, r_den};
    assign trial_diff = trial - {1'b0, r_den};

    assign c_prod  = 32'(SIN_C) * 32'(r_z2);
    assign t1_full = SIN_B - c_prod[29:14];
    assign b_prod  = 32'(r_z2) * 32'(r_t1);
    assign t2_full = SIN_A - b_prod[29:14];
    assign a_prod  = 32'(r_z) * 32'(r_t2);

    assign mag_prod = 30'(r_quo) * 30'(r_s);

    assign pos_inc  = {1'b0, r_pos} + 21'd1;
    assign pos_wrap = pos_inc >= {1'b0, period_eff};
    assign mag16    = {1'b0, r_mag};
    assign is_last  = (r_left == CNT_W'(1));
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_pos       <= '0;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_left  <= i_q_data;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    // Restart the beat if the period was lowered to or below the position
                    if (r_pos >= period_eff) begin
                        r_pos   <= '0;
                        r_phase <= '0;
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_z   <= z_fold;
                    r_neg <= quad[1];
                    if (!in_tone) begin
                        r_num <= '0;
                        r_den <= 20'd1;
                    end else if (in_rise) begin
                        r_num <= r_pos;
                        r_den <= i_cfg.attack;
                    end else if (in_flat) begin
                        r_num <= 20'd1;
                        r_den <= 20'd1;
                    end else begin
                        r_num <= tone_left;
                        r_den <= i_cfg.decay;
                    end
                    r_state <= S_MULT;
                end
                S_MULT: begin
                    r_rem   <= lvl_prod[34:15];
                    r_dlow  <= lvl_prod[14:0];
                    r_quo   <= '0;
                    r_z2    <= z_sq[28:14];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= trial_ge ? trial_diff[19:0] : trial[19:0];
                    r_dlow <= {r_dlow[13:0], 1'b0};
                    r_quo  <= {r_quo[13:0], trial_ge};
                    case (r_cnt)
                        SIN_STEP_T1:  r_t1 <= t1_full[14:0];
                        SIN_STEP_T2:  r_t2 <= t2_full;
                        SIN_STEP_MAG: r_s  <= a_prod[29] ? 15'h7FFF : a_prod[28:14];
                        default: begin
                        end
                    endcase
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_ENV;
                    end
                end
                S_ENV: begin
                    r_mag   <= mag_prod[29:15];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_sample    <= r_neg ? signed'(16'd0 - mag16) : signed'(mag16);
                        r_last      <= is_last;
                        if (pos_wrap) begin
                            r_pos   <= '0;
                            r_phase <= '0;
                        end else begin
                            r_pos   <= pos_inc[19:0];
                            r_phase <= r_phase + step_scaled;
                        end
                        r_left  <= r_left - CNT_W'(1);
                        r_state <= is_last ? S_IDLE : S_WRAP;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_last      = r_last;

    `MTBG_ASSERT_IMP(a_eng_busy_has_work, i_clk, i_rst_n, r_state != S_IDLE, r_left != '0)
    `MTBG_ASSERT_NXT(a_eng_last_ends, i_clk, i_rst_n, out_load && is_last, r_state == S_IDLE)
    `MTBG_ASSERT_NXT(a_eng_load_shows, i_clk, i_rst_n, out_load, r_out_valid && (r_last == $past(is_last)))

endmodule

`default_nettype wire

// File: hw/rtl/metronome_tone_burst_generator_unit.sv
// Top level of the metronome tone burst generator.
//
// Usage: each request transfer on the input channel (i_in_valid / o_in_stall)
// carries i_frames, the number of audio samples wanted. Requests above
// MAX_BLOCK are clamped to MAX_BLOCK; a request of zero frames is taken and
// yields nothing. The output channel (o_out_valid / i_out_stall) then
// delivers that many signed Q1.15 samples on o_sample, with o_last high on
// the final one. Configuration registers are written through i_cfg_we,
// i_cfg_index and i_cfg_data while the block is idle; indexes beyond the
// register list are ignored.
//
// The engine works on one sample at a time, and its pace is set mainly
// by the 15-step restoring divider for the envelope, with the sine
// polynomial run alongside it on its own multipliers. A four-entry queue
// holds pending requests, so the front keeps taking requests while the
// engine is busy, until the queue is full.
// Reset loads the default configuration and clears position, phase, queue
// and output. When the receiver stalls, the finished sample holds in the
// output register and the engine waits with the next sample ready.
`timescale 1ns / 1ps
`default_nettype none

module metronome_tone_burst_generator_unit
    import mtbg_pkg::*;
#(
    parameter int MAX_BLOCK       = 64,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [6:0]            i_frames,
    // Sample channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_sample,
    output logic                  o_last
);

    // Wide enough to hold MAX_BLOCK itself
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    t_cfg             cfg;
    logic             q_full;
    logic             q_push;
    logic [CNT_W-1:0] q_push_data;
    logic             q_pop;
    logic             q_empty;
    logic [CNT_W-1:0] q_rd_data;

    // Front: hold configuration, clamp and forward requests
    mtbg_front #(
        .MAX_BLOCK (MAX_BLOCK),
        .CNT_W     (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_frames    (i_frames),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // Queue: buffer pending frame counts between front and engine
    mtbg_queue #(
        .WIDTH (CNT_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_rd_data   (q_rd_data)
    );

    // Engine: generate one sample at a time and drive the output register
    mtbg_engine #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .CNT_W           (CNT_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rd_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// File: tb/tb_metronome_tone_burst_generator_unit.sv
// Self-checking testbench for the metronome tone burst generator top level.
`timescale 1ns / 1ps

module tb_metronome_tone_burst_generator_unit;
    import mtbg_pkg::*;

    // Block size cap and sine resolution of the instance under test
    localparam int MAX_FRAMES    = 64;
    localparam int SINE_BITS     = 10;
    // Sine polynomial coefficients, Q15
    localparam longint unsigned POLY_A = 51472;
    localparam longint unsigned POLY_B = 21024;
    localparam longint unsigned POLY_C = 2320;
    // Register indexes past the end of the register list; writes there do nothing
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    // Quiet time after the last sample, before the next register write
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_PRINTED   = 100;

    typedef struct {
        logic [6:0] frames;
        int         gap;
    } t_request;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_click_sample;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [6:0]            i_frames    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [15:0]    o_sample;
    logic                  o_last;

    // Predictor state: its own copy of the registers, beat position and phase
    t_cfg        cfg_model = '{
        period:     20'd48000,
        tone:       20'd4800,
        attack:     20'd48,
        decay:      20'd480,
        phase_step: 24'd307582,
        max_level:  15'd16384
    };
    int unsigned beat_pos  = 0;
    logic [23:0] angle     = '0;

    t_request      block_requests[$];
    t_click_sample click_samples[$];
    t_request      next_req;
    t_click_sample want;
    int            gap_count  = 0;
    int            stall_left = 0;
    int            errors     = 0;
    int            sample_no  = 0;
    bit            tx_calm    = 1'b1;
    bit            rx_calm    = 1'b1;

    metronome_tone_burst_generator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_frames    (i_frames),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Sine magnitude in Q15 from the top SINE_BITS of the phase; neg marks
    // the second half-turn.
    function automatic longint unsigned sine_mag(input logic [23:0] ph, output bit neg);
        logic [15:0]     a16;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        longint unsigned r;
        a16 = {ph[23 -: SINE_BITS], {(16 - SINE_BITS){1'b0}}};
        z   = a16[13:0];
        // fold the odd quadrants back onto the rising quarter
        if (a16[14]) begin
            z = 16384 - z;
        end
        neg = a16[15];
        z2  = (z * z) >> 14;
        t   = POLY_B - ((POLY_C * z2) >> 14);
        t   = POLY_A - ((z2 * t) >> 14);
        r   = (z * t) >> 14;
        if (r > 32767) begin
            r = 32767;
        end
        return r;
    endfunction

    // Envelope level at tone position i: rise, flat, fall, tested in that order.
    function automatic longint unsigned env_level(input int unsigned i);
        longint unsigned lvl;
        lvl = cfg_model.max_level;
        if (i < cfg_model.attack) begin
            return (lvl * i) / cfg_model.attack;
        end
        if (longint'(i) + cfg_model.decay < cfg_model.tone) begin
            return lvl;
        end
        return (lvl * (cfg_model.tone - i)) / cfg_model.decay;
    endfunction

    // Work out the samples that one accepted request produces and queue them.
    task automatic render_block(input logic [6:0] frames);
        int unsigned     n;
        int unsigned     per;
        longint unsigned mag;
        longint unsigned m;
        bit              neg;
        t_click_sample   s;
        n   = (frames > MAX_FRAMES) ? MAX_FRAMES : frames;
        per = (cfg_model.period == 0) ? 1 : cfg_model.period;
        for (int unsigned k = 0; k < n; k++) begin
            s.sample = '0;
            // a lowered period can leave the position past the wrap point
            if (beat_pos >= per) begin
                beat_pos = 0;
                angle    = '0;
            end
            if (beat_pos < cfg_model.tone) begin
                mag = sine_mag(angle, neg);
                m   = (env_level(beat_pos) * mag) >> 15;
                s.sample = neg ? -16'(m) : 16'(m);
            end
            s.last = (k + 1 == n);
            click_samples.push_back(s);
            beat_pos = beat_pos + 1;
            angle    = angle + cfg_model.phase_step;
            if (beat_pos >= per) begin
                beat_pos = 0;
                angle    = '0;
            end
        end
    endtask

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: present the next queued request once its gap is over,
    // hold it while stalled.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_count  <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (block_requests.size() != 0 && gap_count >= block_requests[0].gap) begin
                next_req = block_requests.pop_front();
                i_in_valid <= 1'b1;
                i_frames   <= next_req.frames;
                gap_count  <= 0;
            end else begin
                i_in_valid <= 1'b0;
                if (block_requests.size() != 0) begin
                    gap_count <= gap_count + 1;
                end
            end
        end
    end

    // Sample receiver: draw a fresh stall length after every transfer.
    always @(posedge i_clk) begin
        int n;
        n = stall_left;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n = draw_wait(rx_calm);
        end
        if (n > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= n - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end
    end

    // Monitor: predict on each request transfer, check each sample transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                render_block(i_frames);
            end
            if (o_out_valid && !i_out_stall) begin
                if (click_samples.size() == 0) begin
                    flag_error($sformatf("sample %0d arrived with nothing expected (%0d, last %0b)",
                                         sample_no, o_sample, o_last));
                end else begin
                    want = click_samples.pop_front();
                    if (o_sample !== want.sample) begin
                        flag_error($sformatf("sample %0d: value %0d, want %0d",
                                             sample_no, o_sample, want.sample));
                    end
                    if (o_last !== want.last) begin
                        flag_error($sformatf("sample %0d: last %0b, want %0b",
                                             sample_no, o_last, want.last));
                    end
                end
                sample_no++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short idles, sometimes long ones, none in calm stretches.
    function automatic int draw_wait(input bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return 0;
        end
        if (r < 8) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(5, 18);
    endfunction

    // Audio-sized blocks most of the time; zero and oversize requests now and then.
    function automatic logic [6:0] draw_frames();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return 7'd0;
        end
        if (r < 70) begin
            return 7'($urandom_range(1, 16));
        end
        if (r < 90) begin
            return 7'($urandom_range(17, 64));
        end
        return 7'($urandom_range(65, 127));
    endfunction

    task automatic queue_request(input logic [6:0] frames);
        t_request r;
        r.frames = frames;
        r.gap    = draw_wait(tx_calm);
        block_requests.push_back(r);
    endtask

    // Write one register on the block and in the predictor.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_PERIOD:    cfg_model.period     = data[19:0];
            REG_TONE:      cfg_model.tone       = data[19:0];
            REG_ATTACK:    cfg_model.attack     = data[19:0];
            REG_DECAY:     cfg_model.decay      = data[19:0];
            REG_STEP:      cfg_model.phase_step = data[23:0];
            REG_MAX_LEVEL: cfg_model.max_level  = data[14:0];
            default: ;
        endcase
    endtask

    // Drop the write enable and step to a falling edge so queued requests
    // land away from the driver's edge.
    task automatic close_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write all six registers; unused upper data bits carry noise.
    task automatic load_setup(input logic [19:0] per, input logic [19:0] tone,
                              input logic [19:0] att, input logic [19:0] dec,
                              input logic [23:0] step, input logic [14:0] lvl);
        write_reg(REG_PERIOD,    {4'($urandom), per});
        write_reg(REG_TONE,      {4'($urandom), tone});
        write_reg(REG_ATTACK,    {4'($urandom), att});
        write_reg(REG_DECAY,     {4'($urandom), dec});
        write_reg(REG_STEP,      step);
        write_reg(REG_MAX_LEVEL, {9'($urandom), lvl});
        close_writes();
    endtask

    task automatic random_setup(input bit wide);
        logic [19:0] per;
        logic [19:0] tone;
        logic [19:0] att;
        logic [19:0] dec;
        logic [23:0] step;
        logic [14:0] lvl;
        int          r;
        if (wide) begin
            per  = 20'($urandom);
            tone = 20'($urandom);
            att  = 20'($urandom);
            dec  = 20'($urandom);
        end else begin
            // short beats so that wraps and all envelope segments come up often
            per  = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 1))
                                                : 20'($urandom_range(2, 300));
            tone = 20'($urandom_range(0, int'(per) + 40));
            att  = 20'($urandom_range(0, int'(tone) + 5));
            dec  = 20'($urandom_range(0, int'(tone) + 5));
        end
        r = $urandom_range(0, 9);
        step = (r == 0) ? 24'h000000 : (r == 1) ? 24'hFFFFFF : 24'($urandom);
        r = $urandom_range(0, 9);
        lvl  = (r == 0) ? 15'd0 : (r == 1) ? 15'h7FFF : 15'($urandom);
        load_setup(per, tone, att, dec, step, lvl);
    endtask

    // Hold until every request has gone and every predicted sample has come.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (block_requests.size() != 0 || i_in_valid || click_samples.size() != 0);
    endtask

    // Drain, then wait out the quiet time before the next register write.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: frame count extremes, zero and oversize requests
        queue_request(7'd1);
        queue_request(7'd0);
        queue_request(7'd64);
        queue_request(7'd127);
        queue_request(7'd65);
        queue_request(7'd0);
        queue_request(7'd3);
        settle();

        // Zero period: every sample sits at position 0 with phase 0
        tx_calm = 1'b0;
        load_setup(20'd0, 20'd5, 20'd0, 20'd0, 24'hFFFFFF, 15'h7FFF);
        queue_request(7'd5);
        queue_request(7'd2);
        settle();

        // Tone longer than the beat, attack plus decay as long as the tone
        rx_calm = 1'b0;
        load_setup(20'd40, 20'd60, 20'd30, 20'd30, 24'h400000, 15'h7FFF);
        queue_request(7'd64);
        queue_request(7'd50);
        settle();

        // Zero level gives silence; advance the position well into the beat
        load_setup(20'd1000, 20'd800, 20'd7, 20'd11, 24'd123457, 15'd0);
        queue_request(7'd64);
        queue_request(7'd40);
        settle();

        // Lower the period below the current position: restart at the next sample
        load_setup(20'd10, 20'd6, 20'd3, 20'd2, 24'd999999, 15'd20000);
        queue_request(7'd15);
        queue_request(7'd1);
        settle();

        // Largest period, tone and attack with zero decay; writes past the register list change nothing
        write_reg(REG_SPARE_LO, 24'($urandom));
        write_reg(REG_SPARE_HI, 24'($urandom));
        load_setup(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd0, 24'h800001, 15'h7FFF);
        queue_request(7'd64);
        settle();

        // Random settings, each with a run of random requests
        for (int p = 0; p < 12; p++) begin
            tx_calm = ($urandom_range(0, 2) == 0);
            rx_calm = ($urandom_range(0, 2) == 0);
            random_setup(p == 5 || p == 9);
            for (int k = 0; k < 20; k++) begin
                // hold the sender until the output has caught up
                if (k == 10 && (p == 0 || $urandom_range(0, 3) == 0)) begin
                    wait_drained();
                end
                queue_request(draw_frames());
            end
            settle();
        end

        if (errors == 0) begin
            $display("metronome_tone_burst_generator_unit: match");
        end else begin
            $display("metronome_tone_burst_generator_unit: mismatch");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #40_000_000;
        $display("metronome_tone_burst_generator_unit: mismatch");
        $finish;
    end

endmodule
